@@ design/pts_pkg.sv @@
`timescale 1ns / 1ps
package pts_pkg;
  localparam int NPRESET = 16;
  localparam int AW = $clog2(NPRESET);
  localparam int CW = $clog2(NPRESET + 1);

  localparam logic [2:0] MODE_CTRL = 3'd0;
  localparam logic [2:0] MODE_DELIV = 3'd1;
  localparam logic [2:0] MODE_REG = 3'd2;
  localparam logic [2:0] MODE_UNREG = 3'd3;
  localparam logic [2:0] MODE_AVAIL = 3'd4;
  localparam logic [2:0] MODE_UNAVAIL = 3'd5;
  localparam logic [2:0] MODE_SETACT = 3'd6;

  localparam logic [7:0] OP_READ = 8'h01;
  localparam logic [7:0] OP_SET = 8'h04;
  localparam logic [7:0] OP_NEXT = 8'h05;
  localparam logic [7:0] OP_PREV = 8'h06;
  localparam logic [7:0] OP_SSET = 8'h07;
  localparam logic [7:0] OP_SNEXT = 8'h08;
  localparam logic [7:0] OP_SPREV = 8'h09;

  localparam logic [2:0] K_STATUS = 3'd0;
  localparam logic [2:0] K_READ = 3'd1;
  localparam logic [2:0] K_GEN = 3'd2;
  localparam logic [2:0] K_DEL = 3'd3;
  localparam logic [2:0] K_AVAIL = 3'd4;
  localparam logic [2:0] K_UNAVAIL = 3'd5;
  localparam logic [2:0] K_ACTIVE = 3'd6;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_BADOP = 4'd1;
  localparam logic [3:0] ST_BADLEN = 4'd2;
  localparam logic [3:0] ST_NOSUB = 4'd3;
  localparam logic [3:0] ST_RANGE = 4'd4;
  localparam logic [3:0] ST_NOTPOSS = 4'd5;
  localparam logic [3:0] ST_UNLIKELY = 4'd6;
  localparam logic [3:0] ST_INVALID = 4'd7;
  localparam logic [3:0] ST_EXISTS = 4'd8;
  localparam logic [3:0] ST_FULL = 4'd9;
  localparam logic [3:0] ST_NOTFOUND = 4'd10;

  localparam int AVAIL_BIT = 1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] opcode;
    logic [3:0] payload_len;
    logic [7:0] preset_index;
    logic [7:0] read_count;
    logic [7:0] properties;
    logic subscribed;
    logic [1:0] select_outcome;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] status;
    logic [7:0] out_index;
    logic [7:0] prior_index;
    logic [7:0] out_properties;
    logic is_last;
    logic run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] props;
  } entry_t;

  // table memory access bundle
  typedef struct packed {
    logic we;
    logic [AW-1:0] waddr;
    entry_t wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

@@ design/pts_if.sv @@
`timescale 1ns / 1ps
interface pts_in_if;
  logic valid;
  logic ready;
  pts_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pts_out_if;
  logic valid;
  logic ready;
  pts_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pts_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/pts_ram.sv @@
`timescale 1ns / 1ps
module pts_ram (
  input  logic clk,
  input  pts_pkg::mem_req_t req,
  output pts_pkg::entry_t rdata
);
  pts_pkg::entry_t mem [pts_pkg::NPRESET];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

@@ design/pts_ctrl.sv @@
`timescale 1ns / 1ps
module pts_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic sync_en,
  input  logic in_valid,
  output logic in_ready,
  input  pts_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output pts_pkg::out_item_t out_data,
  output pts_pkg::mem_req_t mreq,
  input  pts_pkg::entry_t mrd
);
  localparam int AW = pts_pkg::AW;
  localparam int CW = pts_pkg::CW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_OUT0  = 7'b0100000,
    S_OUT1  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  pts_pkg::in_item_t item_r;
  logic [CW-1:0] count_r;
  logic [7:0] active_r, rstart_r, rrem_r;
  // scan results over the table
  logic [CW-1:0] scan_r;       // scan read address; scan_addr_r holds the address of the entry being returned
  logic scan_vld_r;
  logic [AW-1:0] scan_addr_r;
  logic at_f_r, fr_f_r, nx_f_r, nalt_f_r, pv_f_r, palt_f_r;
  logic [AW-1:0] at_p_r, fr_p_r, nx_p_r, nalt_p_r, pv_p_r, palt_p_r;
  pts_pkg::entry_t at_e_r, fr_e_r, nx_e_r, nalt_e_r, pv_e_r, palt_e_r;
  logic [AW-1:0] ins_p_r;
  logic ins_f_r;
  pts_pkg::entry_t ins_prev_r;
  logic [CW-1:0] sh_r;
  logic sh_rd_r;
  logic sh_up_r;
  logic [AW-1:0] wr_addr_r;
  pts_pkg::entry_t wr_data_r;
  pts_pkg::out_item_t o0_r, o1_r;
  logic has1_r;

  wire [7:0] key = item_r.preset_index;
  wire ent_av = mrd.props[pts_pkg::AVAIL_BIT];

  assign in_ready = (state_r == S_IDLE);

  // combinational decode results
  logic [3:0] st;
  logic f_v;
  pts_pkg::out_item_t f_o;
  logic [7:0] op;
  logic do_w;
  logic [AW-1:0] w_a;
  pts_pkg::entry_t w_d;
  logic do_sh;
  logic sh_up;
  logic [CW-1:0] cnt_n;
  logic [7:0] act_n, rs_n, rr_n;
  logic sel_f;
  pts_pkg::entry_t sel_e;

  always_comb begin
    st = pts_pkg::ST_OK;
    f_v = 1'b0;
    f_o = '0;
    op = item_r.opcode;
    do_w = 1'b0;
    w_a = at_p_r;
    w_d = at_e_r;
    do_sh = 1'b0;
    sh_up = 1'b0;
    cnt_n = count_r;
    act_n = active_r;
    rs_n = rstart_r;
    rr_n = rrem_r;
    sel_f = 1'b0;
    sel_e = at_e_r;
    if (op == pts_pkg::OP_SSET || op == pts_pkg::OP_SNEXT || op == pts_pkg::OP_SPREV) begin
      op = sync_en ? op - 8'd3 : 8'd0;
    end
    unique case (item_r.mode)
      pts_pkg::MODE_CTRL: begin
        case (op)
          pts_pkg::OP_READ: begin
            if (item_r.payload_len < 4'd2) st = pts_pkg::ST_BADLEN;
            else if (!item_r.subscribed) st = pts_pkg::ST_NOSUB;
            else if (!fr_f_r) st = pts_pkg::ST_RANGE;
            else if (rrem_r != 8'd0) st = pts_pkg::ST_NOTPOSS;
            else if (item_r.read_count != 8'd0) begin
              f_v = 1'b1;
              f_o.kind = pts_pkg::K_READ;
              f_o.out_index = fr_e_r.idx;
              f_o.out_properties = fr_e_r.props;
              f_o.is_last = (item_r.read_count == 8'd1) ||
                            ({1'b0, fr_p_r} + 1'b1 >= count_r);
              if (f_o.is_last) rr_n = 8'd0;
              else begin
                rs_n = fr_e_r.idx + 8'd1;
                rr_n = item_r.read_count - 8'd1;
              end
            end
          end
          pts_pkg::OP_SET: begin
            if (item_r.payload_len < 4'd1) st = pts_pkg::ST_BADLEN;
            else if (!at_f_r || key == 8'd0) st = pts_pkg::ST_RANGE;
            else if (!at_e_r.props[pts_pkg::AVAIL_BIT]) st = pts_pkg::ST_NOTPOSS;
            else sel_f = 1'b1;
            sel_e = at_e_r;
          end
          pts_pkg::OP_NEXT: begin
            if (nx_f_r) begin sel_f = 1'b1; sel_e = nx_e_r; end
            else if (nalt_f_r) begin sel_f = 1'b1; sel_e = nalt_e_r; end
            else st = pts_pkg::ST_NOTPOSS;
          end
          pts_pkg::OP_PREV: begin
            if (pv_f_r) begin sel_f = 1'b1; sel_e = pv_e_r; end
            else if (palt_f_r) begin sel_f = 1'b1; sel_e = palt_e_r; end
            else st = pts_pkg::ST_NOTPOSS;
          end
          default: st = pts_pkg::ST_BADOP;
        endcase
        if (sel_f) begin
          case (item_r.select_outcome)
            2'd1: st = pts_pkg::ST_OK;
            2'd2: st = pts_pkg::ST_NOTPOSS;
            2'd3: st = pts_pkg::ST_UNLIKELY;
            default: begin
              if (sel_e.idx != active_r) begin
                act_n = sel_e.idx;
                f_v = 1'b1;
                f_o.kind = pts_pkg::K_ACTIVE;
                f_o.out_index = sel_e.idx;
              end
            end
          endcase
        end
      end
      pts_pkg::MODE_SETACT: begin
        if (key != 8'd0) begin
          if (!at_f_r) st = pts_pkg::ST_NOTFOUND;
          else if (!at_e_r.props[pts_pkg::AVAIL_BIT]) st = pts_pkg::ST_INVALID;
        end
        if (st == pts_pkg::ST_OK && key != active_r) begin
          act_n = key;
          f_v = 1'b1;
          f_o.kind = pts_pkg::K_ACTIVE;
          f_o.out_index = key;
        end
      end
      pts_pkg::MODE_REG: begin
        if (key == 8'd0) st = pts_pkg::ST_INVALID;
        else if (at_f_r) st = pts_pkg::ST_EXISTS;
        else if (count_r >= CW'(pts_pkg::NPRESET)) st = pts_pkg::ST_FULL;
        else begin
          do_w = 1'b1;
          do_sh = 1'b1;
          sh_up = 1'b1;
          w_a = ins_f_r ? ins_p_r : AW'(count_r);
          w_d.idx = key;
          w_d.props = item_r.properties;
          cnt_n = count_r + 1'b1;
          f_v = item_r.subscribed;
          f_o.kind = pts_pkg::K_GEN;
          f_o.out_index = key;
          f_o.prior_index = ins_prev_r.idx;
          f_o.out_properties = item_r.properties;
          f_o.is_last = 1'b1;
        end
      end
      pts_pkg::MODE_UNREG, pts_pkg::MODE_AVAIL, pts_pkg::MODE_UNAVAIL: begin
        if (key == 8'd0) st = pts_pkg::ST_INVALID;
        else if (!at_f_r) st = pts_pkg::ST_NOTFOUND;
        else if (item_r.mode == pts_pkg::MODE_UNREG) begin
          do_sh = 1'b1;
          do_w = 1'b1;
          w_a = AW'(count_r - 1'b1);
          w_d = '0;
          cnt_n = count_r - 1'b1;
          f_v = item_r.subscribed;
          f_o.kind = pts_pkg::K_DEL;
          f_o.out_index = key;
          f_o.is_last = 1'b1;
        end else if ((item_r.mode == pts_pkg::MODE_AVAIL) !=
                     at_e_r.props[pts_pkg::AVAIL_BIT]) begin
          do_w = 1'b1;
          w_a = at_p_r;
          w_d = at_e_r;
          w_d.props[pts_pkg::AVAIL_BIT] = (item_r.mode == pts_pkg::MODE_AVAIL);
          f_v = item_r.subscribed;
          f_o.kind = (item_r.mode == pts_pkg::MODE_AVAIL) ? pts_pkg::K_AVAIL
                                                           : pts_pkg::K_UNAVAIL;
          f_o.out_index = key;
          f_o.is_last = 1'b1;
        end
      end
      pts_pkg::MODE_DELIV: begin
        // delivery confirmation
        if (!item_r.subscribed) rr_n = 8'd0;
        else if (!fr_f_r) begin
          f_v = 1'b1;
          f_o.kind = pts_pkg::K_READ;
          f_o.status = pts_pkg::ST_RANGE;
          f_o.is_last = 1'b1;
          rr_n = 8'd0;
        end else begin
          f_v = 1'b1;
          f_o.kind = pts_pkg::K_READ;
          f_o.out_index = fr_e_r.idx;
          f_o.out_properties = fr_e_r.props;
          f_o.is_last = (rrem_r <= 8'd1) || ({1'b0, fr_p_r} + 1'b1 >= count_r);
          if (f_o.is_last) rr_n = 8'd0;
          else begin
            rs_n = fr_e_r.idx + 8'd1;
            rr_n = rrem_r - 8'd1;
          end
        end
      end
      default: begin
        // unknown mode leaves all state alone
      end
    endcase
  end

  wire [7:0] scan_key = (item_r.mode == pts_pkg::MODE_DELIV) ? rstart_r :
                        (item_r.mode == pts_pkg::MODE_CTRL && item_r.opcode == pts_pkg::OP_READ)
                        ? key : rstart_r;
  wire scan_done = (scan_r >= count_r);

  // memory port: scan read, shift read/write, final write
  always_comb begin
    mreq = '0;
    mreq.raddr = AW'(scan_r);
    if (state_r == S_SHIFT) begin
      mreq.raddr = sh_up_r ? AW'(sh_r - 1'b1) : AW'(sh_r + 1'b1);
      mreq.we = sh_rd_r;
      mreq.waddr = AW'(sh_r);
      mreq.wdata = mrd;
    end else if (state_r == S_WRITE) begin
      mreq.we = 1'b1;
      mreq.waddr = wr_addr_r;
      mreq.wdata = wr_data_r;
    end
  end

  // shift stepping: up moves entries from count-1 down to ins_p; down from at_p to count-2
  logic sh_more;
  always_comb begin
    if (sh_up_r) sh_more = (sh_r > {1'b0, wr_addr_r});
    else sh_more = (sh_r + 2'd2 < count_r + 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: if (scan_done && !scan_vld_r) state_nxt = S_DEC;
      S_DEC: state_nxt = do_sh ? S_SHIFT : (do_w ? S_WRITE : S_OUT0);
      S_SHIFT: if (sh_rd_r && !sh_more) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT0;
      S_OUT0: if (out_ready) state_nxt = has1_r ? S_OUT1 : S_IDLE;
      S_OUT1: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      active_r <= '0;
      rstart_r <= '0;
      rrem_r <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN) begin
        scan_vld_r <= !scan_done;
      end else begin
        scan_vld_r <= 1'b0;
      end
      if (state_r == S_DEC && item_r.mode != pts_pkg::MODE_DELIV) begin
        count_r <= cnt_n;
        active_r <= act_n;
        rstart_r <= rs_n;
        rrem_r <= rr_n;
      end else if (state_r == S_DEC && rrem_r != 8'd0) begin
        rstart_r <= rs_n;
        rrem_r <= rr_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      item_r <= in_data;
      scan_r <= '0;
      {at_f_r, fr_f_r, nx_f_r, nalt_f_r, pv_f_r, palt_f_r, ins_f_r} <= '0;
      ins_prev_r <= '0;
    end
    if (state_r == S_SCAN) begin
      if (!scan_done) scan_r <= scan_r + 1'b1;
      scan_addr_r <= AW'(scan_r);
      if (scan_vld_r) begin
        if (mrd.idx == key) begin at_f_r <= 1'b1; at_p_r <= scan_addr_r; at_e_r <= mrd; end
        if (!fr_f_r && mrd.idx >= scan_key) begin
          fr_f_r <= 1'b1; fr_p_r <= scan_addr_r; fr_e_r <= mrd;
        end
        if (!ins_f_r && mrd.idx > key) begin ins_f_r <= 1'b1; ins_p_r <= scan_addr_r; end
        if (mrd.idx < key) ins_prev_r <= mrd;
        if (ent_av) begin
          if (mrd.idx < active_r) begin
            if (!nalt_f_r) begin nalt_f_r <= 1'b1; nalt_e_r <= mrd; end
            pv_f_r <= 1'b1; pv_e_r <= mrd;
          end else if (mrd.idx > active_r) begin
            if (!nx_f_r) begin nx_f_r <= 1'b1; nx_e_r <= mrd; end
            palt_f_r <= 1'b1; palt_e_r <= mrd;
          end
        end
      end
    end
    if (state_r == S_DEC) begin
      wr_addr_r <= w_a;
      wr_data_r <= w_d;
      sh_up_r <= sh_up;
      sh_rd_r <= 1'b0;
      sh_r <= sh_up ? count_r : {1'b0, at_p_r};
      o0_r <= '0;
      o0_r.kind <= pts_pkg::K_STATUS;
      o0_r.status <= st;
      o0_r.run_last <= !f_v;
      o1_r <= f_o;
      o1_r.run_last <= 1'b1;
      has1_r <= f_v;
      if (item_r.mode == pts_pkg::MODE_DELIV) begin
        // delivery produces only its read response, or nothing
        o0_r <= f_o;
        o0_r.run_last <= 1'b1;
        has1_r <= 1'b0;
      end
    end
    if (state_r == S_SHIFT) begin
      if (!sh_rd_r) sh_rd_r <= 1'b1;
      else if (sh_more) begin
        sh_rd_r <= 1'b0;
        sh_r <= sh_up_r ? sh_r - 1'b1 : sh_r + 1'b1;
      end
    end
  end

  // delivery with nothing pending or not subscribed, and any unknown mode, has no output
  logic deliv_skip;
  always_ff @(posedge clk) begin
    if (state_r == S_DEC) begin
      deliv_skip <= (item_r.mode == pts_pkg::MODE_DELIV &&
                     (rrem_r == 8'd0 || !item_r.subscribed)) ||
                    (item_r.mode > pts_pkg::MODE_SETACT);
    end
  end

  assign out_valid = ((state_r == S_OUT0) && !deliv_skip) || (state_r == S_OUT1);
  assign out_data = (state_r == S_OUT1) ? o1_r : o0_r;
endmodule

@@ design/preset_table_selector_core.sv @@
`timescale 1ns / 1ps
// order of work: a table scan, a decode step, for register and unregister a shift of
// the moved entries, a table write where the table changes, then the results
// flow control: one transaction at a time; a new request is accepted only in the idle
// state, after the previous results have been delivered
// reset: synchronous active low, table empty, count and indices zero
module preset_table_selector_core (
  input logic clk,
  input logic rst_n,
  pts_in_if.sink in_ch,
  pts_out_if.source out_ch,
  pts_cfg_if.sink cfg_ch
);
  logic sync_en_r;
  pts_pkg::mem_req_t mreq;
  pts_pkg::entry_t mrd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) sync_en_r <= 1'b0;
    else if (cfg_ch.valid) sync_en_r <= cfg_ch.data;
  end

  pts_ram u_ram (.clk(clk), .req(mreq), .rdata(mrd));

  pts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sync_en(sync_en_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .mreq(mreq), .mrd(mrd)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while results pending");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> !in_ch.ready) else $error("table written while idle");
`endif
endmodule

@@ verif/tb_preset_table_selector_core.sv @@
`timescale 1ns / 1ps
module tb_preset_table_selector_core;
  import pts_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS = 430;

  class preset_table_checker;
    logic [7:0] tbl_idx[NPRESET];
    logic [7:0] tbl_prop[NPRESET];
    int n_presets;
    logic [7:0] active_idx;
    logic [7:0] rd_start;
    logic [7:0] rd_left;
    logic sync_en;
    out_item_t expected_results[$];
    out_item_t follow_q[$];
    int n_errors;

    function new();
      foreach (tbl_idx[i]) begin
        tbl_idx[i] = '0;
        tbl_prop[i] = '0;
      end
      n_presets = 0;
      active_idx = '0;
      rd_start = '0;
      rd_left = '0;
      sync_en = 1'b0;
      n_errors = 0;
    endfunction

    function void emit(logic [2:0] k, logic [3:0] st, logic [7:0] ix, logic [7:0] pv,
                       logic [7:0] pr, logic lst);
      out_item_t r;
      r.kind = k;
      r.status = st;
      r.out_index = ix;
      r.prior_index = pv;
      r.out_properties = pr;
      r.is_last = lst;
      r.run_last = 1'b0;
      follow_q.push_back(r);
    endfunction

    function int find_at(logic [7:0] x);
      for (int i = 0; i < n_presets; i++) if (tbl_idx[i] == x) return i;
      return -1;
    endfunction

    function int find_from(logic [7:0] x);
      for (int i = 0; i < n_presets; i++) if (tbl_idx[i] >= x) return i;
      return -1;
    endfunction

    function logic [3:0] select_preset(int pos, logic [1:0] oc);
      if (oc == 2'd1) return ST_OK;
      if (oc == 2'd2) return ST_NOTPOSS;
      if (oc == 2'd3) return ST_UNLIKELY;
      if (tbl_idx[pos] != active_idx) begin
        active_idx = tbl_idx[pos];
        emit(K_ACTIVE, ST_OK, active_idx, 8'd0, 8'd0, 1'b0);
      end
      return ST_OK;
    endfunction

    function void stream_one(logic sub);
      int pos;
      logic lst;
      if (!sub) begin
        rd_left = '0;
        return;
      end
      pos = find_from(rd_start);
      if (pos < 0) begin
        emit(K_READ, ST_RANGE, 8'd0, 8'd0, 8'd0, 1'b1);
        rd_left = '0;
        return;
      end
      lst = 1'b1;
      if (rd_left > 8'd1) lst = !(pos + 1 < n_presets);
      emit(K_READ, ST_OK, tbl_idx[pos], 8'd0, tbl_prop[pos], lst);
      if (lst) begin
        rd_left = '0;
      end else begin
        rd_start = tbl_idx[pos] + 8'd1;
        rd_left--;
      end
    endfunction

    function logic [3:0] control_write(in_item_t t);
      logic [7:0] op;
      int pick;
      int alt;
      int pos;
      op = t.opcode;
      if (op >= OP_SSET && op <= OP_SPREV) op = sync_en ? op - (OP_SSET - OP_SET) : 8'd0;
      case (op)
        OP_READ: begin
          if (t.payload_len < 4'd2) return ST_BADLEN;
          if (!t.subscribed) return ST_NOSUB;
          if (find_from(t.preset_index) < 0) return ST_RANGE;
          if (rd_left != 0) return ST_NOTPOSS;
          rd_start = t.preset_index;
          rd_left = t.read_count;
          if (rd_left != 0) stream_one(t.subscribed);
          return ST_OK;
        end
        OP_SET: begin
          if (t.payload_len < 4'd1) return ST_BADLEN;
          pos = find_at(t.preset_index);
          if (pos < 0 || t.preset_index == 0) return ST_RANGE;
          if (!tbl_prop[pos][AVAIL_BIT]) return ST_NOTPOSS;
          return select_preset(pos, t.select_outcome);
        end
        OP_NEXT: begin
          pick = -1;
          alt = -1;
          for (int i = 0; i < n_presets; i++) begin
            if (!tbl_prop[i][AVAIL_BIT]) continue;
            if (tbl_idx[i] < active_idx) begin
              if (alt < 0) alt = i;
              continue;
            end
            if (tbl_idx[i] > active_idx) begin
              pick = i;
              break;
            end
          end
          if (pick < 0) pick = alt;
          return (pick < 0) ? ST_NOTPOSS : select_preset(pick, t.select_outcome);
        end
        OP_PREV: begin
          pick = -1;
          alt = -1;
          for (int i = 0; i < n_presets; i++) begin
            if (!tbl_prop[i][AVAIL_BIT]) continue;
            if (tbl_idx[i] < active_idx) pick = i;
            else if (tbl_idx[i] > active_idx) alt = i;
          end
          if (pick < 0) pick = alt;
          return (pick < 0) ? ST_NOTPOSS : select_preset(pick, t.select_outcome);
        end
        default: return ST_BADOP;
      endcase
    endfunction

    function void note_request(in_item_t t);
      logic [3:0] st;
      logic has_status;
      int pos;
      out_item_t batch[$];
      out_item_t s;
      follow_q.delete();
      st = ST_OK;
      has_status = 1'b1;
      case (t.mode)
        MODE_CTRL: st = control_write(t);
        MODE_DELIV: begin
          has_status = 1'b0;
          if (rd_left != 0) stream_one(t.subscribed);
        end
        MODE_SETACT: begin
          if (t.preset_index != 0) begin
            pos = find_at(t.preset_index);
            if (pos < 0) st = ST_NOTFOUND;
            else if (!tbl_prop[pos][AVAIL_BIT]) st = ST_INVALID;
          end
          if (st == ST_OK && t.preset_index != active_idx) begin
            active_idx = t.preset_index;
            emit(K_ACTIVE, ST_OK, t.preset_index, 8'd0, 8'd0, 1'b0);
          end
        end
        MODE_REG, MODE_UNREG, MODE_AVAIL, MODE_UNAVAIL: begin
          if (t.preset_index == 0) begin
            st = ST_INVALID;
          end else if (t.mode == MODE_REG) begin
            if (find_at(t.preset_index) >= 0) st = ST_EXISTS;
            else if (n_presets >= NPRESET) st = ST_FULL;
            else begin
              pos = n_presets;
              while (pos > 0 && tbl_idx[pos-1] > t.preset_index) begin
                tbl_idx[pos] = tbl_idx[pos-1];
                tbl_prop[pos] = tbl_prop[pos-1];
                pos--;
              end
              tbl_idx[pos] = t.preset_index;
              tbl_prop[pos] = t.properties;
              n_presets++;
              if (t.subscribed)
                emit(K_GEN, ST_OK, t.preset_index, pos > 0 ? tbl_idx[pos-1] : 8'd0,
                     t.properties, 1'b1);
            end
          end else begin
            pos = find_at(t.preset_index);
            if (pos < 0) begin
              st = ST_NOTFOUND;
            end else if (t.mode == MODE_UNREG) begin
              for (int i = pos; i + 1 < n_presets; i++) begin
                tbl_idx[i] = tbl_idx[i+1];
                tbl_prop[i] = tbl_prop[i+1];
              end
              n_presets--;
              tbl_idx[n_presets] = '0;
              tbl_prop[n_presets] = '0;
              if (t.subscribed) emit(K_DEL, ST_OK, t.preset_index, 8'd0, 8'd0, 1'b1);
            end else if (t.mode == MODE_AVAIL) begin
              if (!tbl_prop[pos][AVAIL_BIT]) begin
                tbl_prop[pos][AVAIL_BIT] = 1'b1;
                if (t.subscribed) emit(K_AVAIL, ST_OK, t.preset_index, 8'd0, 8'd0, 1'b1);
              end
            end else begin
              if (tbl_prop[pos][AVAIL_BIT]) begin
                tbl_prop[pos][AVAIL_BIT] = 1'b0;
                if (t.subscribed) emit(K_UNAVAIL, ST_OK, t.preset_index, 8'd0, 8'd0, 1'b1);
              end
            end
          end
        end
        default: has_status = 1'b0;
      endcase
      if (has_status) begin
        s = '0;
        s.kind = K_STATUS;
        s.status = st;
        batch.push_back(s);
      end
      foreach (follow_q[i]) batch.push_back(follow_q[i]);
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      n_errors++;
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (expected_results.size() == 0) begin
        report("unexpected result, kind", int'(r.kind), -1);
        return;
      end
      e = expected_results.pop_front();
      if (r.kind != e.kind) report("kind", int'(r.kind), int'(e.kind));
      if (r.status != e.status) report("status", int'(r.status), int'(e.status));
      if (r.out_index != e.out_index)
        report("out_index", int'(r.out_index), int'(e.out_index));
      if (r.prior_index != e.prior_index)
        report("prior_index", int'(r.prior_index), int'(e.prior_index));
      if (r.out_properties != e.out_properties)
        report("out_properties", int'(r.out_properties), int'(e.out_properties));
      if (r.is_last != e.is_last) report("is_last", int'(r.is_last), int'(e.is_last));
      if (r.run_last != e.run_last) report("run_last", int'(r.run_last), int'(e.run_last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  pts_in_if in_ch();
  pts_out_if out_ch();
  pts_cfg_if cfg_ch();

  preset_table_checker sb = new();
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  logic xfer_seen;

  preset_table_selector_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // scoreboard hooks and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      xfer_seen = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.sync_en = cfg_ch.data;
        xfer_seen = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.data);
        xfer_seen = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.data);
        xfer_seen = 1'b1;
      end
      quiet_cycles <= xfer_seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  function automatic in_item_t mk(logic [2:0] m, logic [7:0] op, logic [3:0] len,
                                  logic [7:0] ix, logic [7:0] cnt, logic [7:0] pr,
                                  logic sub, logic [1:0] oc);
    in_item_t t;
    t.mode = m;
    t.opcode = op;
    t.payload_len = len;
    t.preset_index = ix;
    t.read_count = cnt;
    t.properties = pr;
    t.subscribed = sub;
    t.select_outcome = oc;
    return t;
  endfunction

  function automatic in_item_t random_request();
    in_item_t t;
    int r;
    t.opcode = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 30) t.mode = MODE_CTRL;
    else if (r < 52) t.mode = MODE_DELIV;
    else if (r < 72) t.mode = MODE_REG;
    else if (r < 80) t.mode = MODE_UNREG;
    else if (r < 87) t.mode = MODE_AVAIL;
    else if (r < 93) t.mode = MODE_UNAVAIL;
    else if (r < 99) t.mode = MODE_SETACT;
    else t.mode = 3'd7;
    r = $urandom_range(99);
    if (r < 80) begin
      case ($urandom_range(6))
        0: t.opcode = OP_READ;
        1: t.opcode = OP_SET;
        2: t.opcode = OP_NEXT;
        3: t.opcode = OP_PREV;
        4: t.opcode = OP_SSET;
        5: t.opcode = OP_SNEXT;
        default: t.opcode = OP_SPREV;
      endcase
    end
    t.payload_len = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(1, 3));
    r = $urandom_range(99);
    if (r < 5) t.preset_index = 8'd0;
    else if (r < 8) t.preset_index = 8'd255;
    else if (r < 13) t.preset_index = 8'($urandom_range(255));
    else t.preset_index = 8'($urandom_range(1, 22));
    r = $urandom_range(99);
    if (r < 5) t.read_count = 8'd0;
    else if (r < 9) t.read_count = 8'd255;
    else if (r < 15) t.read_count = 8'($urandom_range(255));
    else t.read_count = 8'($urandom_range(1, 6));
    t.properties = 8'($urandom_range(255));
    if ($urandom_range(99) < 60) t.properties[AVAIL_BIT] = 1'b1;
    t.subscribed = ($urandom_range(99) < 85);
    t.select_outcome = ($urandom_range(1) == 0) ? 2'd0 : 2'($urandom_range(3));
    return t;
  endfunction

  task automatic push_item(in_item_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_sync(logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    in_item_t dir[$];
    int idle_set[4];
    int stall_set[4];
    logic sync_set[4];
    idle_set = '{0, 52, 0, 24};
    stall_set = '{0, 0, 52, 24};
    sync_set = '{1'b1, 1'b0, 1'b1, 1'b1};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_sync(1'b0);

    // empty table, boundaries, every mode, and the read, set, next and sync set opcodes
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd2, 8'd0, 8'd3, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_DELIV, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_NEXT, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_REG, 8'd0, 4'd0, 8'd255, 8'd0, 8'hFF, 1'b1, 2'd0));
    dir.push_back(mk(MODE_REG, 8'd0, 4'd0, 8'd1, 8'd0, 8'h00, 1'b1, 2'd0));
    dir.push_back(mk(MODE_REG, 8'd0, 4'd0, 8'd7, 8'd0, 8'h02, 1'b0, 2'd0));
    dir.push_back(mk(MODE_REG, 8'd0, 4'd0, 8'd0, 8'd0, 8'h02, 1'b1, 2'd0));
    dir.push_back(mk(MODE_REG, 8'd0, 4'd0, 8'd7, 8'd0, 8'h02, 1'b1, 2'd0));
    dir.push_back(mk(MODE_UNREG, 8'd0, 4'd0, 8'd9, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_AVAIL, 8'd0, 4'd0, 8'd1, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_UNAVAIL, 8'd0, 4'd0, 8'd255, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_SETACT, 8'd0, 4'd0, 8'd77, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_SETACT, 8'd0, 4'd0, 8'd255, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_SETACT, 8'd0, 4'd0, 8'd7, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_SETACT, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd1, 8'd0, 8'd2, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd2, 8'd0, 8'd2, 8'd0, 1'b0, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd15, 8'd0, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd2, 8'd1, 8'd255, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_READ, 4'd2, 8'd1, 8'd1, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_UNREG, 8'd0, 4'd0, 8'd7, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_DELIV, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_SET, 4'd0, 8'd255, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(MODE_CTRL, OP_SSET, 4'd1, 8'd255, 8'd0, 8'd0, 1'b1, 2'd0));
    dir.push_back(mk(3'd7, 8'hFF, 4'd15, 8'd255, 8'd255, 8'hFF, 1'b1, 2'd3));
    foreach (dir[i]) push_item(dir[i]);
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_sync(sync_set[ph]);
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          @(negedge clk);
          while (sb.expected_results.size() != 0) @(negedge clk);
        end
        push_item(random_request());
      end
      in_ch.valid <= 1'b0;
    end

    settle();
    if (sb.n_errors == 0 && sb.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/pts_pkg.sv
design/pts_if.sv
design/pts_ram.sv
design/pts_ctrl.sv
design/preset_table_selector_core.sv
verif/tb_preset_table_selector_core.sv
